### rtl/core/bblur_pkg.sv
// shared types, constants and the reciprocal table for the 3x3 box blur core
// no dependencies; imported by every module of the core
package bblur_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // pixel arithmetic
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int SUM_W       = 12;          // nine channels of 8 bits plus rounding
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

    // red in the lowest bits, as on the stream
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    // one line store word: both buffered rows at one column
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_word_t;

    // which window taps lie inside the frame
    typedef struct packed {
        logic have;
        logic last;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } tap_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } sums_t;

    typedef struct packed {
        logic       last;
        logic [1:0] rows;
        logic [1:0] cols;
    } sum_ctl_t;

    // ceil(2^16 / count): exact quotient for every sum the window can produce
    function automatic logic [RECIP_W-1:0] count_recip(input logic [3:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd2:    r = RECIP_W'((RECIP_ONE + 1) / 2);
            4'd3:    r = RECIP_W'((RECIP_ONE + 2) / 3);
            4'd4:    r = RECIP_W'((RECIP_ONE + 3) / 4);
            4'd6:    r = RECIP_W'((RECIP_ONE + 5) / 6);
            4'd9:    r = RECIP_W'((RECIP_ONE + 8) / 9);
            default: r = RECIP_W'(RECIP_ONE);
        endcase
        return r;
    endfunction

endpackage

### rtl/core/box_blur_3x3_edge_average_core.sv
// 3x3 box blur over an rgb pixel stream: position tracking, pipeline control, top level
// depends on bblur_pkg, bblur_line_store, bblur_window and bblur_divide
//
// One pixel (or drain item) is taken per clock as long as the output is taken; the
// rate is set by the line store, whose single memory gives one read and one write
// each cycle. A result passes the stage 1, window, sum and output registers after the
// item that completes its window, one row plus one pixel behind the input; after the
// frame, frame_width+1 drain items (tuser high) flush the rest, and the final result
// carries tlast. Each channel is the half-up rounded mean of the neighbours inside the
// frame (4 at corners, 6 on edges, 9 inside, if both sizes are 2 or more). Sizes of 0
// act as 1 and sizes over the maximum as the maximum. The line store is not cleared
// after reset; stale words reach only masked taps. Write configuration only while idle.
module box_blur_3x3_edge_average_core
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // pixel input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,    // in_red, in_green, in_blue
    input  logic                 s_axis_tuser,    // command (1 = drain item)
    // blurred output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,    // out_red, out_green, out_blue
    output logic                 m_axis_tlast     // frame_last
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    // stream position of the next item
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // stage 1: line store read in flight
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    pixel_t           s1_px_reg;
    tap_ctl_t         s1_ctl_reg;

    logic [WCNT_W-1:0] w_eff;
    logic [HCNT_W-1:0] h_eff;
    logic [31:0]       w32;
    logic [31:0]       h32;
    logic [31:0]       col32;
    logic [31:0]       row32;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic              pos_wrap;
    pixel_t            px_in;
    tap_ctl_t          ctl_in;
    logic              advance;
    logic              accept;

    line_word_t rd_word;
    line_word_t wr_word;
    logic       s3_valid;
    sums_t      s3_sums;
    sum_ctl_t   s3_ctl;
    pixel_t     out_px;

    // whole pipeline moves whenever the output register can take a result
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp the frame size into the supported range
    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WCNT_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_eff = WCNT_W'(MAX_WIDTH);
        else
            w_eff = WCNT_W'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = HCNT_W'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HCNT_W'(MAX_HEIGHT);
        else
            h_eff = HCNT_W'(frame_height_reg);
    end

    assign w32 = 32'(w_eff);
    assign h32 = 32'(h_eff);

    // a position left beyond the frame by a size change restarts the frame
    assign pos_wrap = (32'(col_reg) >= w32) || (32'(row_reg) > h32 + 32'd1);
    assign col_cur  = pos_wrap ? '0 : col_reg;
    assign row_cur  = pos_wrap ? '0 : row_reg;
    assign col32    = 32'(col_cur);
    assign row32    = 32'(row_cur);

    // drain items and anything past the last row feed zeros
    assign px_in = (row32 < h32 && !s_axis_tuser) ? pixel_t'(s_axis_tdata) : '0;

    // window centre sits one pixel back; at column zero it is the end of the row before
    always_comb
    begin
        ctl_in = '0;
        if (col_cur != '0)
        begin
            ctl_in.have   = (row32 >= 32'd1) && (row32 <= h32);
            ctl_in.top    = row32 >= 32'd2;
            ctl_in.bottom = row32 < h32;
            ctl_in.left   = col32 >= 32'd2;
            ctl_in.right  = 1'b1;
            ctl_in.last   = 1'b0;
        end
        else
        begin
            ctl_in.have   = (row32 >= 32'd2) && (row32 <= h32 + 32'd1);
            ctl_in.top    = row32 >= 32'd3;
            ctl_in.bottom = row32 <= h32;
            ctl_in.left   = w32 >= 32'd2;
            ctl_in.right  = 1'b0;
            ctl_in.last   = row32 == h32 + 32'd1;
        end
    end

    // raster advance; the frame's final result returns to the start
    always_comb
    begin
        if (ctl_in.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col32 + 32'd1 >= w32)
        begin
            col_next = '0;
            row_next = ROW_W'(row32 + 32'd1);
        end
        else
        begin
            col_next = COL_W'(col32 + 32'd1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (advance)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_col_reg <= col_cur;
            s1_px_reg  <= px_in;
            s1_ctl_reg <= ctl_in;
        end
    end

    // rows move up one: middle becomes upper, the new pixel becomes middle
    assign wr_word.upper  = rd_word.middle;
    assign wr_word.middle = s1_px_reg;

    bblur_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance),
        .rd_addr (col_cur),
        .wr_en   (advance && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word),
        .rd_data (rd_word)
    );

    bblur_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .s1_valid (s1_valid_reg),
        .s1_rd    (rd_word),
        .s1_px    (s1_px_reg),
        .s1_ctl   (s1_ctl_reg),
        .s3_valid (s3_valid),
        .s3_sums  (s3_sums),
        .s3_ctl   (s3_ctl)
    );

    bblur_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s3_valid  (s3_valid),
        .s3_sums   (s3_sums),
        .s3_ctl    (s3_ctl),
        .out_valid (m_axis_tvalid),
        .out_px    (out_px),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_px;

endmodule

### rtl/core/bblur_line_store.sv
// two-row line store in one synchronous memory, one read and one write a cycle
// depends on bblur_pkg; forwards a write that hits the address being read
module bblur_line_store
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  line_word_t       wr_data,
    output line_word_t       rd_data
);

    line_word_t mem [MAX_WIDTH];
    line_word_t rd_data_reg;
    line_word_t fwd_data_reg;
    logic       fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // read and write of the same column in one cycle (single-column frames, frame restarts)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

### rtl/core/bblur_window.sv
// 3x3 window registers and the masked channel sums
// depends on bblur_pkg; fed from the line store read and the incoming pixel
module bblur_window
    import bblur_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       s1_valid,
    input  line_word_t s1_rd,
    input  pixel_t     s1_px,
    input  tap_ctl_t   s1_ctl,
    output logic       s3_valid,
    output sums_t      s3_sums,
    output sum_ctl_t   s3_ctl
);

    pixel_t   win_reg [3][3];
    logic     s2_valid_reg;
    tap_ctl_t s2_ctl_reg;
    logic     s3_valid_reg;
    sums_t    s3_sums_reg;
    sum_ctl_t s3_ctl_reg;

    logic [2:0] row_ok;
    logic [2:0] col_ok;
    sums_t      sums_next;

    // window shifts left, new column from the stores and the input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (advance && s1_valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= s1_rd.upper;
            win_reg[1][2] <= s1_rd.middle;
            win_reg[2][2] <= s1_px;
        end
    end

    assign row_ok = {s2_ctl_reg.bottom, 1'b1, s2_ctl_reg.top};
    assign col_ok = {s2_ctl_reg.right, 1'b1, s2_ctl_reg.left};

    always_comb
    begin
        sums_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_ok[r] && col_ok[c])
                begin
                    sums_next.red   = sums_next.red   + SUM_W'(win_reg[r][c].red);
                    sums_next.green = sums_next.green + SUM_W'(win_reg[r][c].green);
                    sums_next.blue  = sums_next.blue  + SUM_W'(win_reg[r][c].blue);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg && s2_ctl_reg.have;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_ctl_reg       <= s1_ctl;
            s3_sums_reg      <= sums_next;
            s3_ctl_reg.last  <= s2_ctl_reg.last;
            s3_ctl_reg.rows  <= 2'd1 + 2'(s2_ctl_reg.top) + 2'(s2_ctl_reg.bottom);
            s3_ctl_reg.cols  <= 2'd1 + 2'(s2_ctl_reg.left) + 2'(s2_ctl_reg.right);
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_sums  = s3_sums_reg;
    assign s3_ctl   = s3_ctl_reg;

endmodule

### rtl/core/bblur_divide.sv
// rounded mean by reciprocal multiply, into the output register
// depends on bblur_pkg; counts are 1, 2, 3, 4, 6 or 9
module bblur_divide
    import bblur_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  logic     s3_valid,
    input  sums_t    s3_sums,
    input  sum_ctl_t s3_ctl,
    output logic     out_valid,
    output pixel_t   out_px,
    output logic     out_last
);

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [3:0]         count;
    logic [RECIP_W-1:0] recip;
    logic [SUM_W-1:0]   half;
    logic [PROD_W-1:0]  prod_red;
    logic [PROD_W-1:0]  prod_green;
    logic [PROD_W-1:0]  prod_blue;

    logic   out_valid_reg;
    pixel_t out_px_reg;
    logic   out_last_reg;

    assign count = 4'(s3_ctl.rows) * 4'(s3_ctl.cols);
    assign recip = count_recip(count);
    assign half  = SUM_W'(count >> 1);

    assign prod_red   = PROD_W'(s3_sums.red   + half) * PROD_W'(recip);
    assign prod_green = PROD_W'(s3_sums.green + half) * PROD_W'(recip);
    assign prod_blue  = PROD_W'(s3_sums.blue  + half) * PROD_W'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_px_reg.red   <= prod_red[RECIP_SHIFT +: CH_W];
            out_px_reg.green <= prod_green[RECIP_SHIFT +: CH_W];
            out_px_reg.blue  <= prod_blue[RECIP_SHIFT +: CH_W];
            out_last_reg     <= s3_ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_px    = out_px_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/core/bblur_checker.sv
// port-level checks for the box blur core, bound onto the top level
// depends on bblur_pkg and box_blur_3x3_edge_average_core
module bblur_checker
    import bblur_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [PIX_W-1:0]     m_axis_tdata,
    input logic                 m_axis_tlast
);

    // a stalled result holds its data and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // an empty output register never holds back the input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output register empty");

    // after reset, a result must pass through the pipeline registers before it appears
    a_reset_latency: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n, 3) |-> !m_axis_tvalid)
        else $error("result appeared too soon after reset");

endmodule

bind box_blur_3x3_edge_average_core bblur_checker u_checker (.*);
